/* hw/rtl/ifc_pkg.sv */
package ifc_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned FRAC_W = 24;
    localparam int unsigned MANT_W = 23;
    localparam int unsigned SHIFT_W = 5;
    localparam int unsigned IBM_EXP_W = 7;
    localparam int unsigned EXP_W = 10;

    // 4*E7 - 256 + 127 = 4*E7 - EXP_OFS: IBM base-16 exponent to IEEE biased exponent
    localparam logic signed [EXP_W-1:0] EXP_OFS = 10'sd129;
    localparam logic signed [EXP_W-1:0] EXP_SAT = 10'sd255;
    localparam logic [WORD_W-2:0] IEEE_MAX_MAG = 31'h7f7fffff;

    typedef struct packed {
        logic [MANT_W-1:0]  mant;
        logic [SHIFT_W-1:0] shift;
    } t_norm;

    function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

/* hw/rtl/ifc_norm.sv */
module ifc_norm (
    input  logic [ifc_pkg::FRAC_W-1:0] i_frac,
    output ifc_pkg::t_norm              o_norm
);

    logic [ifc_pkg::FRAC_W-1:0] m0;
    logic [ifc_pkg::FRAC_W-1:0] m1;
    logic [ifc_pkg::FRAC_W-1:0] m2;
    logic [ifc_pkg::FRAC_W-1:0] m3;
    logic [ifc_pkg::FRAC_W-1:0] m4;
    logic [ifc_pkg::FRAC_W-1:0] m5;
    logic [4:0]                 zc;

    // drop the lowest fraction bit, then a five-step leading-zero shift
    assign m0    = {1'b0, i_frac[ifc_pkg::FRAC_W-1:1]};
    assign zc[4] = (m0[23:8] == 16'd0);
    assign m1    = zc[4] ? {m0[7:0], 16'd0} : m0;
    assign zc[3] = (m1[23:16] == 8'd0);
    assign m2    = zc[3] ? {m1[15:0], 8'd0} : m1;
    assign zc[2] = (m2[23:20] == 4'd0);
    assign m3    = zc[2] ? {m2[19:0], 4'd0} : m2;
    assign zc[1] = (m3[23:22] == 2'd0);
    assign m4    = zc[1] ? {m3[21:0], 2'd0} : m3;
    assign zc[0] = !m4[23];
    assign m5    = zc[0] ? {m4[22:0], 1'b0} : m4;

    always_comb begin
        if (m0 == '0) begin
            // nothing left to normalize: exponent stays put
            o_norm.mant  = '0;
            o_norm.shift = '0;
        end else begin
            o_norm.mant  = m5[ifc_pkg::MANT_W-1:0];
            o_norm.shift = zc;
        end
    end

endmodule

/* hw/rtl/ibm_float_to_ieee_single.sv */
// IBM hexadecimal float to IEEE single converter. Each beat on i_raw_word is one
// sample word in file byte order; the result on o_ieee_bits is the byte-swapped
// word, converted from IBM float when the mode register is 1 (its reset value).
// The block takes one beat per clock while o_stall is low; each accepted beat passes
// through its register stages in order: one captures and byte-swaps, one holds the
// leading-zero normalized fraction, one holds the rebased, clamped result.
// Stalls stop only the stages that are full, so bubbles close up.
// i_cfg_data sets the mode; write it only when the pipe is empty.
module ibm_float_to_ieee_single (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_raw_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_ieee_bits
);

    logic                                   r_ibm_mode;
    logic                                   r_v1, r_v2, r_v3;
    logic                                   adv1, adv2, adv3;
    logic [ifc_pkg::WORD_W-1:0]             r_w1, r_w2;
    logic                                   r_m1, r_m2;
    ifc_pkg::t_norm                         norm;
    ifc_pkg::t_norm                         r_norm2;
    logic                                   r_zero2;
    logic [ifc_pkg::WORD_W-1:0]             r_out3;
    logic [ifc_pkg::WORD_W-1:0]             n_out3;
    logic signed [ifc_pkg::EXP_W-1:0]       x;

    assign o_cfg_ready = 1'b1;

    assign adv3    = !r_v3 || !i_stall;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ibm_mode <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ibm_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_w1 <= ifc_pkg::swap_bytes(i_raw_word);
            r_m1 <= r_ibm_mode;
        end
        if (adv2) begin
            r_w2    <= r_w1;
            r_m2    <= r_m1;
            r_norm2 <= norm;
            r_zero2 <= (r_w1[ifc_pkg::FRAC_W-1:0] == '0);
        end
        if (adv3) begin
            r_out3 <= n_out3;
        end
    end

    ifc_norm u_norm (
        .i_frac (r_w1[ifc_pkg::FRAC_W-1:0]),
        .o_norm (norm)
    );

    assign x = $signed({1'b0, r_w2[30:24], 2'b00}) - ifc_pkg::EXP_OFS
             - $signed({5'd0, r_norm2.shift});

    always_comb begin
        if (!r_m2) begin
            n_out3 = r_w2;
        end else if (r_zero2) begin
            n_out3 = {r_w2[31], 31'd0};
        end else if (x >= ifc_pkg::EXP_SAT) begin
            n_out3 = {r_w2[31], ifc_pkg::IEEE_MAX_MAG};
        end else if (x <= 10'sd0) begin
            // no denormal rescaling: keep sign and mantissa only
            n_out3 = {r_w2[31], 8'd0, r_norm2.mant};
        end else begin
            n_out3 = {r_w2[31], x[7:0], r_norm2.mant};
        end
    end

    assign o_valid     = r_v3;
    assign o_ieee_bits = r_out3;

endmodule

/* hw/rtl/ifc_checker.sv */
module ifc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic        i_cfg_data,
    input logic        i_valid,
    input logic        o_stall,
    input logic [31:0] i_raw_word,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_ieee_bits
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_ieee_bits))
        else $error("stalled result beat changed");

    // an empty output stage never pushes back on the input
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output stage");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

    // an accepted beat comes out when the output does not stall in between
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("result beat missing after three cycles");

endmodule

bind ibm_float_to_ieee_single ifc_checker u_ifc_checker (.*);
